/* sv/crfbr_pkg.sv */
package crfbr_pkg;

   localparam int MAX_RESPONSES = 8;
   localparam int MAX_DELAY_MS  = 1000;
   localparam int TRIG_STD_ID   = 1552;
   localparam int TABLE_DEPTH   = 8;
   localparam int MAX_LENGTH    = 8;
   localparam int ALLOW_COUNT   = 5;

   localparam int IDX_W   = 3;
   localparam int IDENT_W = 29;
   localparam int LEN_W   = 4;
   localparam int WAIT_W  = 16;
   localparam int TOTAL_W = 4;
   localparam int OUTID_W = 11;

   // outcome codes
   localparam logic [1:0] OUTCOME_LOAD     = 2'd0;
   localparam logic [1:0] OUTCOME_IGNORED  = 2'd1;
   localparam logic [1:0] OUTCOME_RESPONSE = 2'd2;

   // request kinds
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_FRAME = 1'b1;

   // csr indexes
   localparam logic [1:0] CSR_ENABLED        = 2'd0;
   localparam logic [1:0] CSR_TRIG_IDENT     = 2'd1;
   localparam logic [1:0] CSR_TRIGGER_LENGTH = 2'd2;
   localparam logic [1:0] CSR_RESPONSE_TOTAL = 2'd3;

   localparam logic [IDENT_W-1:0] ALLOW_LIST [ALLOW_COUNT] = '{
      29'h610, 29'h613, 29'h615, 29'h316, 29'h329
   };

   typedef struct packed {
      logic [IDENT_W-1:0] ident;
      logic [LEN_W-1:0]   length;
      logic [WAIT_W-1:0]  wait_ms;
   } entry_type;

   typedef struct packed {
      logic                   ok;
      logic [ALLOW_COUNT-1:0] seen;
   } check_type;

endpackage

/* sv/can_remote_frame_burst_responder_unit.sv */
// Load transaction: the ack reaches the response register in the next cycle,
// then ready again once that register is free. Frame transaction: ignored at
// once when a register or frame check fails; otherwise each table entry goes
// through the shared entry checker (ignored if one fails), then one result per
// entry, one per cycle when the sink keeps rsp_tready high.
// Reset (synchronous, active high) clears the table, the registers and the FSM.
module can_remote_frame_burst_responder_unit (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // slot, frame_id, frame_dlc, delay_ms, is_extended, is_remote
   input  logic        req_tuser,  // req_type
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // outcome, out_slot, out_ident, out_length, wait_before_ms
   output logic        rsp_tlast,  // last_of_burst
   // configuration
   input  logic        csr_wen,
   input  logic [1:0]  csr_index,
   input  logic [28:0] csr_wdata
);
   import crfbr_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CHECK = 2'd1;
   localparam logic [1:0] ST_EMIT  = 2'd2;

   // request fields
   logic [IDX_W-1:0]   req_slot;
   logic [IDENT_W-1:0] req_frame_id;
   logic [LEN_W-1:0]   req_frame_dlc;
   logic [WAIT_W-1:0]  req_delay_ms;
   logic               req_is_extended;
   logic               req_is_remote;

   assign req_slot        = req_tdata[2:0];
   assign req_frame_id    = req_tdata[31:3];
   assign req_frame_dlc   = req_tdata[35:32];
   assign req_delay_ms    = req_tdata[51:36];
   assign req_is_extended = req_tdata[52];
   assign req_is_remote   = req_tdata[53];

   // config registers
   logic               enabled_ff;
   logic [IDENT_W-1:0] trig_ident_ff;
   logic [LEN_W-1:0]   trigger_length_ff;
   logic [TOTAL_W-1:0] response_total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff        <= 1'b0;
         trig_ident_ff     <= '0;
         trigger_length_ff <= '0;
         response_total_ff <= '0;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_ENABLED:        enabled_ff        <= csr_wdata[0];
            CSR_TRIG_IDENT:     trig_ident_ff     <= csr_wdata;
            CSR_TRIGGER_LENGTH: trigger_length_ff <= csr_wdata[LEN_W-1:0];
            CSR_RESPONSE_TOTAL: response_total_ff <= csr_wdata[TOTAL_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer state
   logic [1:0]             state_ff, state_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [ALLOW_COUNT-1:0] seen_ff, seen_in;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_outcome_ff, rsp_outcome_in;
   logic [IDX_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [OUTID_W-1:0] rsp_ident_ff, rsp_ident_in;
   logic [LEN_W-1:0]   rsp_length_ff, rsp_length_in;
   logic [WAIT_W-1:0]  rsp_wait_ff, rsp_wait_in;
   logic               rsp_last_ff, rsp_last_in;

   entry_type  rd_entry;
   entry_type  wr_entry;
   check_type  chk;
   logic       req_accept;
   logic       table_we;
   logic       rsp_free;
   logic       pre_ok;
   logic       idx_is_last;

   assign wr_entry = '{ident: req_frame_id, length: req_frame_dlc, wait_ms: req_delay_ms};

   crfbr_table u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (table_we),
      .wr_addr  (req_slot),
      .wr_entry (wr_entry),
      .rd_addr  (idx_ff),
      .rd_entry (rd_entry)
   );

   // one entry checked per cycle in ST_CHECK
   crfbr_check u_check (
      .entry  (rd_entry),
      .first  (idx_ff == '0),
      .seen   (seen_ff),
      .result (chk)
   );

   assign rsp_free    = !rsp_valid_ff || rsp_tready;
   assign req_tready  = (state_ff == ST_IDLE) && rsp_free;
   assign req_accept  = req_tvalid && req_tready;
   assign table_we    = req_accept && (req_tuser == REQ_LOAD);
   assign idx_is_last = ({1'b0, idx_ff} + TOTAL_W'(1)) == response_total_ff;

   // checks that need no table walk: registers and the frame itself
   assign pre_ok = enabled_ff &&
                   (trig_ident_ff == IDENT_W'(TRIG_STD_ID)) &&
                   (trigger_length_ff <= LEN_W'(MAX_LENGTH)) &&
                   (response_total_ff != '0) &&
                   (response_total_ff <= TOTAL_W'(MAX_RESPONSES)) &&
                   (req_frame_id == trig_ident_ff) &&
                   (req_frame_dlc == trigger_length_ff) &&
                   !req_is_extended && req_is_remote;

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      seen_in        = seen_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_ident_in   = rsp_ident_ff;
      rsp_length_in  = rsp_length_ff;
      rsp_wait_in    = rsp_wait_ff;
      rsp_last_in    = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_tuser == REQ_LOAD) begin
                  rsp_valid_in   = 1'b1;
                  rsp_outcome_in = OUTCOME_LOAD;
                  rsp_slot_in    = '0;
                  rsp_ident_in   = '0;
                  rsp_length_in  = '0;
                  rsp_wait_in    = '0;
                  rsp_last_in    = 1'b1;
               end else if (!pre_ok) begin
                  rsp_valid_in   = 1'b1;
                  rsp_outcome_in = OUTCOME_IGNORED;
                  rsp_slot_in    = '0;
                  rsp_ident_in   = '0;
                  rsp_length_in  = '0;
                  rsp_wait_in    = '0;
                  rsp_last_in    = 1'b1;
               end else begin
                  idx_in   = '0;
                  seen_in  = '0;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (!chk.ok) begin
               // wait for room, then report ignored
               if (rsp_free) begin
                  rsp_valid_in   = 1'b1;
                  rsp_outcome_in = OUTCOME_IGNORED;
                  rsp_slot_in    = '0;
                  rsp_ident_in   = '0;
                  rsp_length_in  = '0;
                  rsp_wait_in    = '0;
                  rsp_last_in    = 1'b1;
                  state_in       = ST_IDLE;
               end
            end else if (idx_is_last) begin
               idx_in   = '0;
               state_in = ST_EMIT;
            end else begin
               idx_in  = idx_ff + IDX_W'(1);
               seen_in = chk.seen;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_outcome_in = OUTCOME_RESPONSE;
               rsp_slot_in    = idx_ff;
               rsp_ident_in   = rd_entry.ident[OUTID_W-1:0];
               rsp_length_in  = rd_entry.length;
               rsp_wait_in    = rd_entry.wait_ms;
               rsp_last_in    = idx_is_last;
               idx_in         = idx_ff + IDX_W'(1);
               if (idx_is_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_ident_ff   <= rsp_ident_in;
      rsp_length_ff  <= rsp_length_in;
      rsp_wait_ff    <= rsp_wait_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {4'b0, rsp_wait_ff, rsp_length_ff, rsp_ident_ff,
                        rsp_slot_ff, rsp_outcome_ff};

endmodule

/* sv/crfbr_table.sv */
module crfbr_table (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [crfbr_pkg::IDX_W-1:0] wr_addr,
   input  crfbr_pkg::entry_type        wr_entry,
   input  logic [crfbr_pkg::IDX_W-1:0] rd_addr,
   output crfbr_pkg::entry_type        rd_entry
);
   import crfbr_pkg::*;

   entry_type entries_ff [TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            entries_ff[i] <= '0;
         end
      end else if (wr_en) begin
         entries_ff[wr_addr] <= wr_entry;
      end
   end

   assign rd_entry = entries_ff[rd_addr];

endmodule

/* sv/crfbr_check.sv */
module crfbr_check (
   input  crfbr_pkg::entry_type                  entry,
   input  logic                                  first,
   input  logic [crfbr_pkg::ALLOW_COUNT-1:0]     seen,
   output crfbr_pkg::check_type                  result
);
   import crfbr_pkg::*;

   logic [ALLOW_COUNT-1:0] hit;
   logic                   head_ok;

   always_comb begin
      for (int k = 0; k < ALLOW_COUNT; k++) begin
         hit[k] = (entry.ident == ALLOW_LIST[k]);
      end
   end

   // entry 0 must carry the trigger id with no delay
   assign head_ok = !first ||
                    ((entry.ident == IDENT_W'(TRIG_STD_ID)) && (entry.wait_ms == '0));

   assign result.ok = (hit != '0) && ((hit & seen) == '0) &&
                      (entry.length <= LEN_W'(MAX_LENGTH)) &&
                      (entry.wait_ms <= WAIT_W'(MAX_DELAY_MS)) && head_ok;
   assign result.seen = seen | hit;

endmodule

/* tb/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import crfbr_pkg::*;

   // Cycles with no transaction on either stream before the run is declared hung.
   localparam int STALL_LIMIT   = 3000;
   // Give stray results time to show up at the end of the run.
   localparam int SETTLE_CYCLES = 40;
   localparam int ITEMS_PER_MODE = 160;

   // One request transaction, unpacked.
   typedef struct {
      logic               kind;     // REQ_LOAD or REQ_FRAME
      logic [IDX_W-1:0]   slot;
      logic [IDENT_W-1:0] ident;
      logic [LEN_W-1:0]   dlc;
      logic [WAIT_W-1:0]  delay;
      logic               ext;
      logic               rtr;
   } frame_req_type;

   // One result transaction, unpacked.
   typedef struct {
      logic [1:0]         outcome;
      logic [IDX_W-1:0]   slot;
      logic [OUTID_W-1:0] ident;
      logic [LEN_W-1:0]   length;
      logic [WAIT_W-1:0]  wait_ms;
      logic               last_flag;
   } frame_rsp_type;

   typedef enum logic {ROW_CSR, ROW_ITEM} row_kind_type;

   // Directed stimulus row: a register write or a request. Rows marked typed
   // carry a hand-written single result (load ack or ignored frame).
   typedef struct {
      row_kind_type       kind;
      logic [1:0]         reg_idx;
      logic [IDENT_W-1:0] reg_val;
      frame_req_type      req;
      bit                 typed;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;   // slot, frame_id, frame_dlc, delay_ms, is_extended, is_remote
   logic        req_tuser = 1'b0; // req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // outcome, out_slot, out_ident, out_length, wait_before_ms
   logic        rsp_tlast;        // last_of_burst
   logic        csr_wen = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [28:0] csr_wdata = '0;

   can_remote_frame_burst_responder_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10ns clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow copy of the block: response table and registers, all zero at reset
   // ---------------------------------------------------------------------
   logic [IDENT_W-1:0] tbl_ident [TABLE_DEPTH] = '{default: '0};
   logic [LEN_W-1:0]   tbl_len   [TABLE_DEPTH] = '{default: '0};
   logic [WAIT_W-1:0]  tbl_wait  [TABLE_DEPTH] = '{default: '0};
   logic               cfg_enabled   = 1'b0;
   logic [IDENT_W-1:0] cfg_trig_ident = '0;
   logic [LEN_W-1:0]   cfg_trig_len   = '0;
   logic [TOTAL_W-1:0] cfg_total      = '0;

   frame_rsp_type pending_responses[$];   // results still owed by the block, oldest first
   int         mismatches    = 0;
   int         items_sent    = 0;
   int         send_idle_pct = 8;
   int         recv_idle_pct = 48;
   int         stall_cycles  = 0;

   // Profile check: trigger registers sane, entry 0 is the trigger id with no
   // delay, and each entry in the burst uses a distinct allowed id with legal
   // length and delay.
   function automatic bit burst_profile_valid();
      bit ok, listed;
      int i, j, k;
      ok = (cfg_trig_ident == TRIG_STD_ID) && (cfg_trig_len <= MAX_LENGTH) &&
           (cfg_total != 0) && (cfg_total <= MAX_RESPONSES) && (cfg_total <= TABLE_DEPTH);
      if (tbl_ident[0] != TRIG_STD_ID || tbl_wait[0] != 0) ok = 1'b0;
      for (i = 0; ok && i < int'(cfg_total); i++) begin
         listed = 1'b0;
         for (k = 0; k < ALLOW_COUNT; k++)
            if (tbl_ident[i] == ALLOW_LIST[k]) listed = 1'b1;
         if (!listed || tbl_len[i] > MAX_LENGTH || tbl_wait[i] > MAX_DELAY_MS) ok = 1'b0;
         for (j = 0; j < i; j++)
            if (tbl_ident[j] == tbl_ident[i]) ok = 1'b0;
      end
      return ok;
   endfunction

   // Applies one accepted request to the shadow state and lists its results.
   function automatic void answer_request(input frame_req_type it,
                                          ref frame_rsp_type outq[$]);
      frame_rsp_type r;
      int i;
      outq.delete();
      r = '{outcome: OUTCOME_IGNORED, slot: '0, ident: '0, length: '0, wait_ms: '0,
            last_flag: 1'b1};
      if (it.kind == REQ_LOAD) begin
         tbl_ident[it.slot] = it.ident;
         tbl_len[it.slot]   = it.dlc;
         tbl_wait[it.slot]  = it.delay;
         r.outcome = OUTCOME_LOAD;
         outq.push_back(r);
      end else if (cfg_enabled && burst_profile_valid() && it.ident == cfg_trig_ident &&
                   it.dlc == cfg_trig_len && !it.ext && it.rtr) begin
         // trigger hit: one response per entry, in table order
         for (i = 0; i < int'(cfg_total); i++) begin
            r.outcome   = OUTCOME_RESPONSE;
            r.slot      = IDX_W'(i);
            r.ident     = tbl_ident[i][OUTID_W-1:0];
            r.length    = tbl_len[i];
            r.wait_ms   = tbl_wait[i];
            r.last_flag = (i + 1 == int'(cfg_total));
            outq.push_back(r);
         end
      end else begin
         outq.push_back(r);
      end
   endfunction

   function automatic logic [55:0] pack_request(input frame_req_type it);
      return {2'b00, it.rtr, it.ext, it.delay, it.dlc, it.ident, it.slot};
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
   endfunction

   // Load with any field value at all, including out-of-range ones.
   function automatic frame_req_type random_load();
      frame_req_type it;
      it.kind  = REQ_LOAD;
      it.slot  = IDX_W'($urandom_range(TABLE_DEPTH - 1));
      it.ident = ($urandom_range(1)) ? ALLOW_LIST[$urandom_range(ALLOW_COUNT - 1)]
                                     : IDENT_W'($urandom());
      it.dlc   = LEN_W'($urandom_range(15));
      it.delay = ($urandom_range(1)) ? WAIT_W'($urandom_range(MAX_DELAY_MS))
                                     : WAIT_W'($urandom_range(65535));
      it.ext   = 1'($urandom_range(1));
      it.rtr   = 1'($urandom_range(1));
      return it;
   endfunction

   function automatic stim_row_type csr_row(input logic [1:0] idx, input logic [28:0] val);
      stim_row_type row;
      row = '{kind: ROW_CSR, reg_idx: idx, reg_val: val, req: '{default: '0}, typed: 1'b0};
      return row;
   endfunction

   function automatic stim_row_type load_row(input int slot, input logic [28:0] ident,
                                             input int dlc, input int delay);
      stim_row_type row;
      row = '{kind: ROW_ITEM, reg_idx: '0, reg_val: '0, req: '{default: '0}, typed: 1'b1};
      row.req.kind  = REQ_LOAD;
      row.req.slot  = IDX_W'(slot);
      row.req.ident = ident;
      row.req.dlc   = LEN_W'(dlc);
      row.req.delay = WAIT_W'(delay);
      return row;
   endfunction

   function automatic stim_row_type frame_row(input logic [28:0] ident, input int dlc,
                                              input bit ext, input bit rtr, input bit typed);
      stim_row_type row;
      row = '{kind: ROW_ITEM, reg_idx: '0, reg_val: '0, req: '{default: '0}, typed: typed};
      row.req.kind  = REQ_FRAME;
      row.req.ident = ident;
      row.req.dlc   = LEN_W'(dlc);
      row.req.ext   = ext;
      row.req.rtr   = rtr;
      return row;
   endfunction

   // ---------------------------------------------------------------------
   // Request side. tvalid stays high after a transaction; it only drops for an
   // idle cycle or when the sender pauses.
   // ---------------------------------------------------------------------
   task automatic send_request(input frame_req_type it, input bit typed);
      frame_rsp_type owed[$];
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.kind;
      req_tdata  <= pack_request(it);
      do @(posedge clock); while (!req_tready);
      answer_request(it, owed);
      if (typed) begin
         // hand-written result: loads ack, frames are ignored
         pending_responses.push_back('{outcome: (it.kind == REQ_LOAD) ? OUTCOME_LOAD
                                                                       : OUTCOME_IGNORED,
                                       slot: '0, ident: '0, length: '0, wait_ms: '0,
                                       last_flag: 1'b1});
      end else begin
         foreach (owed[i]) pending_responses.push_back(owed[i]);
      end
      items_sent++;
   endtask

   // Sender pause: hold off until every owed result has been taken.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
   endtask

   // Leaves csr_wen high; the caller drops it after the last write of a group.
   task automatic write_csr(input logic [1:0] idx, input logic [28:0] val);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_ENABLED:        cfg_enabled    = val[0];
         CSR_TRIG_IDENT:     cfg_trig_ident = val;
         CSR_TRIGGER_LENGTH: cfg_trig_len   = val[LEN_W-1:0];
         CSR_RESPONSE_TOTAL: cfg_total      = val[TOTAL_W-1:0];
         default: ;
      endcase
   endtask

   // One random session: reprogram the registers while idle, load a table
   // (mostly a well-formed profile), then fire a handful of frames, mostly
   // real triggers with random payload fields.
   task automatic run_session();
      logic [IDENT_W-1:0] t_ident;
      logic [LEN_W-1:0]   t_len;
      logic [TOTAL_W-1:0] t_total;
      int idmap[5];
      int i, s, pick, tmp, n, roll, start;
      frame_req_type it;

      drain();
      roll = $urandom_range(99);
      if (roll < 80)      t_ident = TRIG_STD_ID;
      else if (roll < 85) t_ident = '0;
      else if (roll < 90) t_ident = '1;
      else                t_ident = IDENT_W'($urandom());
      t_len = ($urandom_range(99) < 85) ? LEN_W'($urandom_range(MAX_LENGTH))
                                        : LEN_W'($urandom_range(15));
      roll = $urandom_range(99);
      if (roll < 85)      t_total = TOTAL_W'($urandom_range(1, ALLOW_COUNT));
      else if (roll < 90) t_total = '0;
      else                t_total = TOTAL_W'($urandom_range(ALLOW_COUNT + 1, 15));
      write_csr(CSR_ENABLED, ($urandom_range(99) < 90) ? 29'd1 : 29'd0);
      write_csr(CSR_TRIG_IDENT, t_ident);
      write_csr(CSR_TRIGGER_LENGTH, 29'(t_len));
      write_csr(CSR_RESPONSE_TOTAL, 29'(t_total));
      csr_wen <= 1'b0;

      if ($urandom_range(99) < 80) begin
         // well-formed profile: slot 0 holds the trigger id, slots 1..4 a
         // shuffle of the other allowed ids; loaded in rotated slot order
         for (i = 0; i < ALLOW_COUNT; i++) idmap[i] = i;
         for (i = ALLOW_COUNT - 1; i > 1; i--) begin
            pick = $urandom_range(1, i);
            tmp = idmap[i]; idmap[i] = idmap[pick]; idmap[pick] = tmp;
         end
         start = $urandom_range(ALLOW_COUNT - 1);
         for (i = 0; i < ALLOW_COUNT; i++) begin
            s = (start + i) % ALLOW_COUNT;
            it.kind  = REQ_LOAD;
            it.slot  = IDX_W'(s);
            it.ident = ALLOW_LIST[idmap[s]];
            it.dlc   = LEN_W'($urandom_range(MAX_LENGTH));
            if (s == 0)
               it.delay = ($urandom_range(99) < 95) ? '0
                                                    : WAIT_W'($urandom_range(1, MAX_DELAY_MS));
            else
               it.delay = WAIT_W'($urandom_range(MAX_DELAY_MS));
            it.ext = 1'($urandom_range(1));
            it.rtr = 1'($urandom_range(1));
            send_request(it, 1'b0);
         end
         if ($urandom_range(99) < 20) begin
            it = random_load();
            it.slot = IDX_W'($urandom_range(ALLOW_COUNT, TABLE_DEPTH - 1));
            send_request(it, 1'b0);
         end
      end else begin
         n = $urandom_range(1, 4);
         for (i = 0; i < n; i++) send_request(random_load(), 1'b0);
      end

      n = $urandom_range(3, 10);
      for (i = 0; i < n; i++) begin
         it.kind  = REQ_FRAME;
         it.slot  = IDX_W'($urandom_range(TABLE_DEPTH - 1));
         it.delay = WAIT_W'($urandom_range(65535));
         it.ident = t_ident;
         it.dlc   = t_len;
         it.ext   = 1'b0;
         it.rtr   = 1'b1;
         roll = $urandom_range(99);
         if (roll < 70) ;                                      // genuine trigger
         else if (roll < 75) it.ext = 1'b1;                    // extended id
         else if (roll < 80) it.rtr = 1'b0;                    // data frame
         else if (roll < 85) it.dlc ^= LEN_W'($urandom_range(1, 15));
         else if (roll < 90) it.ident ^= IDENT_W'(1) << $urandom_range(IDENT_W - 1);
         else if (roll < 95) begin                             // garbage frame
            it.ident = IDENT_W'($urandom());
            it.dlc   = LEN_W'($urandom_range(15));
            it.ext   = 1'($urandom_range(1));
            it.rtr   = 1'($urandom_range(1));
         end else it = random_load();                          // table rewritten mid-stream
         send_request(it, 1'b0);
      end
   endtask

   // ---------------------------------------------------------------------
   // Result side: random backpressure and in-order checking
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      frame_rsp_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{outcome: rsp_tdata[1:0], slot: rsp_tdata[4:2], ident: rsp_tdata[15:5],
                    length: rsp_tdata[19:16], wait_ms: rsp_tdata[35:20],
                    last_flag: rsp_tlast};
            if (pending_responses.size() == 0) begin
               mismatches++;
               $display("%0t: result transaction, expected none, actual 0x%0h last %0b",
                        $time, rsp_tdata, rsp_tlast);
            end else begin
               want = pending_responses.pop_front();
               compare_field("outcome", 32'(want.outcome), 32'(got.outcome));
               compare_field("out_slot", 32'(want.slot), 32'(got.slot));
               compare_field("out_ident", 32'(want.ident), 32'(got.ident));
               compare_field("out_length", 32'(want.length), 32'(got.length));
               compare_field("wait_before_ms", 32'(want.wait_ms), 32'(got.wait_ms));
               compare_field("last_of_burst", 32'(want.last_flag), 32'(got.last_flag));
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: any transaction on either stream resets the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      stim_row_type directed[$];
      int mode, target;

      // nothing configured yet: any frame is ignored
      directed.push_back(frame_row(29'h610, 8, 1'b0, 1'b1, 1'b1));
      // build a five-entry profile; slot 7 gets the field maxima and stays unused
      directed.push_back(load_row(0, 29'h610, 8, 0));
      directed.push_back(load_row(1, 29'h613, 0, MAX_DELAY_MS));
      directed.push_back(load_row(2, 29'h615, 3, 17));
      directed.push_back(load_row(3, 29'h316, 8, 999));
      directed.push_back(load_row(4, 29'h329, 1, 500));
      directed.push_back(load_row(7, 29'h1FFFFFFF, 15, 16'hFFFF));
      directed.push_back(csr_row(CSR_ENABLED, 29'd1));
      directed.push_back(csr_row(CSR_TRIG_IDENT, 29'h610));
      directed.push_back(csr_row(CSR_TRIGGER_LENGTH, 29'd8));
      directed.push_back(csr_row(CSR_RESPONSE_TOTAL, 29'd5));
      // full burst, then each way a frame can miss the trigger
      directed.push_back(frame_row(29'h610, 8, 1'b0, 1'b1, 1'b0));
      directed.push_back(frame_row(29'h610, 8, 1'b1, 1'b1, 1'b1));
      directed.push_back(frame_row(29'h610, 8, 1'b0, 1'b0, 1'b1));
      directed.push_back(frame_row(29'h610, 7, 1'b0, 1'b1, 1'b1));
      directed.push_back(frame_row(29'h611, 8, 1'b0, 1'b1, 1'b1));
      // single-entry burst
      directed.push_back(csr_row(CSR_RESPONSE_TOTAL, 29'd1));
      directed.push_back(frame_row(29'h610, 8, 1'b0, 1'b1, 1'b0));
      // count reaching an entry that was never set up
      directed.push_back(csr_row(CSR_RESPONSE_TOTAL, 29'd6));
      directed.push_back(frame_row(29'h610, 8, 1'b0, 1'b1, 1'b1));
      // count at register maximum and at zero
      directed.push_back(csr_row(CSR_RESPONSE_TOTAL, 29'd15));
      directed.push_back(frame_row(29'h610, 8, 1'b0, 1'b1, 1'b1));
      directed.push_back(csr_row(CSR_RESPONSE_TOTAL, 29'd0));
      directed.push_back(frame_row(29'h610, 8, 1'b0, 1'b1, 1'b1));
      // disabled
      directed.push_back(csr_row(CSR_RESPONSE_TOTAL, 29'd5));
      directed.push_back(csr_row(CSR_ENABLED, 29'd0));
      directed.push_back(frame_row(29'h610, 8, 1'b0, 1'b1, 1'b1));
      // trigger length beyond 8, even when the frame matches it
      directed.push_back(csr_row(CSR_ENABLED, 29'd1));
      directed.push_back(csr_row(CSR_TRIGGER_LENGTH, 29'd9));
      directed.push_back(frame_row(29'h610, 9, 1'b0, 1'b1, 1'b1));
      // trigger id at both extremes, not the fixed trigger id
      directed.push_back(csr_row(CSR_TRIGGER_LENGTH, 29'd8));
      directed.push_back(csr_row(CSR_TRIG_IDENT, 29'h1FFFFFFF));
      directed.push_back(frame_row(29'h1FFFFFFF, 8, 1'b0, 1'b1, 1'b1));
      directed.push_back(csr_row(CSR_TRIG_IDENT, 29'd0));
      directed.push_back(frame_row(29'd0, 8, 1'b0, 1'b1, 1'b1));
      directed.push_back(csr_row(CSR_TRIG_IDENT, 29'h610));
      // duplicate id in the table
      directed.push_back(load_row(1, 29'h610, 0, 0));
      directed.push_back(frame_row(29'h610, 8, 1'b0, 1'b1, 1'b1));
      // delay one past the limit
      directed.push_back(load_row(1, 29'h613, 0, MAX_DELAY_MS + 1));
      directed.push_back(frame_row(29'h610, 8, 1'b0, 1'b1, 1'b1));
      // entry 0 with a nonzero delay
      directed.push_back(load_row(0, 29'h610, 8, 1));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[r]) begin
         if (directed[r].kind == ROW_CSR) begin
            drain();
            write_csr(directed[r].reg_idx, directed[r].reg_val);
         end else begin
            csr_wen <= 1'b0;
            send_request(directed[r].req, directed[r].typed);
         end
      end

      // random part: light sender gaps with heavy backpressure, then the
      // reverse, then both sides flat out
      for (mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin send_idle_pct = 8;  recv_idle_pct = 48; end
            1: begin send_idle_pct = 48; recv_idle_pct = 8;  end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         target = items_sent + ITEMS_PER_MODE;
         while (items_sent < target) run_session();
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_responses.size() == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule

/* can_remote_frame_burst_responder_unit.f */
sv/crfbr_pkg.sv
sv/crfbr_table.sv
sv/crfbr_check.sv
sv/can_remote_frame_burst_responder_unit.sv
tb/testbench.sv
